// File: hdl/psstat_pkg.sv
package psstat_pkg;

  localparam int VAL_W  = 32;
  localparam int FRAC_W = 16;
  localparam int DIV_W  = 48;

  localparam logic signed [VAL_W-1:0] S32_MAX = 32'sh7fff_ffff;
  localparam logic signed [VAL_W-1:0] S32_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic fold;
    logic clear;
  } acc_ctrl_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [VAL_W-1:0] divisor;
  } div_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// File: hdl/psstat_in_if.sv
interface psstat_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] resistance;
  logic signed [31:0] voltage;
  logic        last_sample;

  modport source (output valid, resistance, voltage, last_sample, input ready);
  modport sink   (input valid, resistance, voltage, last_sample, output ready);
endinterface

// File: hdl/psstat_out_if.sv
interface psstat_out_if #(
  parameter int CNT_W = 11
);
  logic              valid;
  logic              ready;
  logic signed [31:0] volt_min;
  logic signed [31:0] volt_max;
  logic signed [31:0] volt_avg;
  logic signed [31:0] amp_min;
  logic signed [31:0] amp_max;
  logic signed [31:0] amp_avg;
  logic signed [31:0] watt_min;
  logic signed [31:0] watt_max;
  logic signed [31:0] watt_avg;
  logic [CNT_W-1:0]  sample_total;

  modport source (
    output valid, volt_min, volt_max, volt_avg, amp_min, amp_max, amp_avg,
           watt_min, watt_max, watt_avg, sample_total,
    input  ready
  );
  modport sink (
    input  valid, volt_min, volt_max, volt_avg, amp_min, amp_max, amp_avg,
           watt_min, watt_max, watt_avg, sample_total,
    output ready
  );
endinterface

// File: hdl/power_sample_statistics_core.sv
// Running min / max / mean of voltage, current and power.
// sample channel: resistance (unsigned Q16.16), voltage (signed Q16.16) and
//   last_sample. Current = V/R and power = V*I are derived per transaction,
//   each saturated to signed 32 bits.
// result channel: min, max and truncated average of each quantity plus the
//   sample count, one transaction per finished set (last_sample, or the
//   MAX_SAMPLES-th sample of a set).
// Flow: a sample with nonzero resistance waits for a current division before
//   ready returns, zero resistance needs no divide; the divider is
//   a 48-step radix-2 unit shared by the current quotient and the averages.
//   A closing sample adds three averaging divisions and then loads the
//   result register.
// Reset clears the statistics, the count and result valid.
// The result is held in an output register: new samples are taken while it
//   waits, and a later set only stalls in its final load if the receiver has
//   not yet taken the previous result.
module power_sample_statistics_core
  import psstat_pkg::*;
#(
  parameter int MAX_SAMPLES = 1024
) (
  input  logic  clk,
  input  logic  rst,
  psstat_in_if.sink    sample,
  psstat_out_if.source result
);

  localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
  localparam int SUM_W = VAL_W + $clog2(MAX_SAMPLES);

  localparam logic [1:0] AVG_V = 2'd0;
  localparam logic [1:0] AVG_I = 2'd1;
  localparam logic [1:0] AVG_W = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE, S_CUR, S_MUL, S_PWR, S_FOLDP, S_AVG, S_AVGW, S_EMIT
  } state_t;

  state_t state;

  logic [VAL_W-1:0]        r_q;
  logic signed [VAL_W-1:0] v_q;
  logic                    last_q;
  logic signed [VAL_W-1:0] amp_q;
  logic signed [VAL_W-1:0] watt_q;
  logic signed [2*VAL_W-1:0] prod_q;
  logic signed [VAL_W-1:0] avg_q [3];
  logic [1:0]              avg_sel;
  logic [CNT_W-1:0]        count;

  acc_ctrl_t   acc_v_ctrl, acc_i_ctrl, acc_w_ctrl;
  div_ctrl_t   div_ctrl;
  div_stat_t   div_stat;
  logic [DIV_W-1:0] quotient;

  logic signed [VAL_W-1:0] lo_v, hi_v, lo_i, hi_i, lo_w, hi_w;
  logic signed [SUM_W-1:0] sum_v, sum_i, sum_w;

  logic                    first;
  logic                    accept;
  logic                    emit_go;
  logic [CNT_W-1:0]        cnt_inc;
  logic [VAL_W-1:0]        v_mag;
  logic signed [SUM_W-1:0] sum_sel;
  logic [SUM_W-1:0]        sum_mag;
  logic                    q_big;
  logic signed [VAL_W-1:0] amp_div;
  logic signed [VAL_W-1:0] amp_zero;
  logic signed [2*VAL_W-1:0] prod_adj;
  logic signed [2*VAL_W-1:0] prod_shr;
  logic                    prod_fits;
  logic signed [VAL_W-1:0] watt_sat;
  logic signed [VAL_W-1:0] avg_val;

  assign sample.ready = (state == S_IDLE);
  assign accept       = sample.valid && sample.ready;
  assign emit_go      = !result.valid || result.ready;
  assign first        = (count == '0);
  assign cnt_inc      = count + 1'b1;

  always_comb begin
    v_mag = sample.voltage[VAL_W-1] ? VAL_W'(-sample.voltage) : sample.voltage;

    unique case (avg_sel)
      AVG_V:   sum_sel = sum_v;
      AVG_I:   sum_sel = sum_i;
      default: sum_sel = sum_w;
    endcase
    sum_mag = sum_sel[SUM_W-1] ? SUM_W'(-sum_sel) : sum_sel;

    div_ctrl.start    = 1'b0;
    div_ctrl.dividend = {v_mag, {FRAC_W{1'b0}}};
    div_ctrl.divisor  = sample.resistance;
    if (state == S_IDLE) begin
      div_ctrl.start = accept && (sample.resistance != '0);
    end else if (state == S_AVG) begin
      div_ctrl.start    = 1'b1;
      div_ctrl.dividend = DIV_W'(sum_mag);
      div_ctrl.divisor  = VAL_W'(count);
    end

    q_big    = |quotient[DIV_W-1:VAL_W-1];
    if (v_q[VAL_W-1]) begin
      amp_div = q_big ? S32_MIN : -$signed(quotient[VAL_W-1:0]);
    end else begin
      amp_div = q_big ? S32_MAX : $signed(quotient[VAL_W-1:0]);
    end
    amp_zero = (v_q > 0) ? S32_MAX : (v_q < 0) ? S32_MIN : '0;

    // divide by 2^16 toward zero, then saturate
    prod_adj  = prod_q + (prod_q[2*VAL_W-1] ? 64'sd65535 : 64'sd0);
    prod_shr  = prod_adj >>> FRAC_W;
    prod_fits = (&prod_shr[2*VAL_W-1:VAL_W-1]) || !(|prod_shr[2*VAL_W-1:VAL_W-1]);
    watt_sat  = prod_fits ? prod_shr[VAL_W-1:0]
              : (prod_shr[2*VAL_W-1] ? S32_MIN : S32_MAX);

    avg_val = sum_sel[SUM_W-1] ? -$signed(quotient[VAL_W-1:0])
                               : $signed(quotient[VAL_W-1:0]);

    acc_v_ctrl.fold  = accept;
    acc_i_ctrl.fold  = (state == S_MUL);
    acc_w_ctrl.fold  = (state == S_FOLDP);
    acc_v_ctrl.clear = (state == S_EMIT) && emit_go;
    acc_i_ctrl.clear = acc_v_ctrl.clear;
    acc_w_ctrl.clear = acc_v_ctrl.clear;
  end

  psstat_div u_div (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (div_ctrl),
    .stat     (div_stat),
    .quotient (quotient)
  );

  psstat_acc #(.SUM_W(SUM_W)) u_acc_v (
    .clk(clk), .rst(rst), .ctrl(acc_v_ctrl), .first(first), .x(sample.voltage),
    .lo(lo_v), .hi(hi_v), .sum(sum_v)
  );

  psstat_acc #(.SUM_W(SUM_W)) u_acc_i (
    .clk(clk), .rst(rst), .ctrl(acc_i_ctrl), .first(first), .x(amp_q),
    .lo(lo_i), .hi(hi_i), .sum(sum_i)
  );

  psstat_acc #(.SUM_W(SUM_W)) u_acc_w (
    .clk(clk), .rst(rst), .ctrl(acc_w_ctrl), .first(first), .x(watt_q),
    .lo(lo_w), .hi(hi_w), .sum(sum_w)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      count        <= '0;
      avg_sel      <= AVG_V;
      result.valid <= 1'b0;
    end else begin
      if (result.valid && result.ready && state != S_EMIT) result.valid <= 1'b0;

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            r_q    <= sample.resistance;
            v_q    <= sample.voltage;
            last_q <= sample.last_sample;
            state  <= S_CUR;
          end
        end
        S_CUR: begin
          if (r_q == '0) begin
            amp_q <= amp_zero;
            state <= S_MUL;
          end else if (div_stat.done) begin
            amp_q <= amp_div;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          prod_q <= v_q * amp_q;
          state  <= S_PWR;
        end
        S_PWR: begin
          watt_q <= watt_sat;
          state  <= S_FOLDP;
        end
        S_FOLDP: begin
          count <= cnt_inc;
          if (last_q || cnt_inc == CNT_W'(MAX_SAMPLES)) begin
            avg_sel <= AVG_V;
            state   <= S_AVG;
          end else begin
            state <= S_IDLE;
          end
        end
        S_AVG: begin
          state <= S_AVGW;
        end
        S_AVGW: begin
          if (div_stat.done) begin
            avg_q[avg_sel] <= avg_val;
            if (avg_sel == AVG_W) begin
              state <= S_EMIT;
            end else begin
              avg_sel <= avg_sel + 1'b1;
              state   <= S_AVG;
            end
          end
        end
        S_EMIT: begin
          if (emit_go) begin
            result.valid        <= 1'b1;
            result.volt_min     <= lo_v;
            result.volt_max     <= hi_v;
            result.volt_avg     <= avg_q[AVG_V];
            result.amp_min      <= lo_i;
            result.amp_max      <= hi_i;
            result.amp_avg      <= avg_q[AVG_I];
            result.watt_min     <= lo_w;
            result.watt_max     <= hi_w;
            result.watt_avg     <= avg_q[AVG_W];
            result.sample_total <= count;
            count               <= '0;
            state               <= S_IDLE;
          end
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_div_start_idle: assert property (@(posedge clk) disable iff (rst)
    div_ctrl.start |-> !div_stat.busy)
    else $error("divider started while busy");

  a_div_done_waited: assert property (@(posedge clk) disable iff (rst)
    div_stat.done |-> (state == S_CUR || state == S_AVGW))
    else $error("divider result not consumed");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_SAMPLES))
    else $error("sample count exceeds set size");

  a_emit_clears: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT && emit_go) |=> (count == '0 && result.valid && sum_v == '0))
    else $error("result load did not clear statistics");
`endif

endmodule

// File: hdl/psstat_div.sv
module psstat_div
  import psstat_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  div_ctrl_t        ctrl,
  output div_stat_t        stat,
  output logic [DIV_W-1:0] quotient
);

  localparam int STEP_W = $clog2(DIV_W + 1);

  logic              busy;
  logic              done;
  logic [STEP_W-1:0] steps;
  logic [VAL_W-1:0]  rem;
  logic [DIV_W-1:0]  dvd;
  logic [VAL_W-1:0]  dvs;

  logic [VAL_W:0]    sh;
  logic              ge;
  logic [VAL_W-1:0]  rem_next;

  // restoring division, one quotient bit per cycle
  always_comb begin
    sh       = {rem, dvd[DIV_W-1]};
    ge       = sh >= {1'b0, dvs};
    rem_next = ge ? VAL_W'(sh - {1'b0, dvs}) : sh[VAL_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (busy) begin
        rem   <= rem_next;
        dvd   <= {dvd[DIV_W-2:0], ge};
        steps <= steps - 1'b1;
        if (steps == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end else if (ctrl.start) begin
        busy  <= 1'b1;
        rem   <= '0;
        dvd   <= ctrl.dividend;
        dvs   <= ctrl.divisor;
        steps <= STEP_W'(DIV_W);
      end
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign quotient  = dvd;

endmodule

// File: hdl/psstat_acc.sv
module psstat_acc
  import psstat_pkg::*;
#(
  parameter int SUM_W = 42
) (
  input  logic                    clk,
  input  logic                    rst,
  input  acc_ctrl_t               ctrl,
  input  logic                    first,
  input  logic signed [VAL_W-1:0] x,
  output logic signed [VAL_W-1:0] lo,
  output logic signed [VAL_W-1:0] hi,
  output logic signed [SUM_W-1:0] sum
);

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      lo  <= '0;
      hi  <= '0;
      sum <= '0;
    end else if (ctrl.fold) begin
      if (first || x < lo) lo <= x;
      if (first || x > hi) hi <= x;
      sum <= sum + SUM_W'(x);
    end
  end

endmodule
